>>> hw/rtl/osvm_pkg.sv
package osvm_pkg;

    localparam int NUM_VOICES  = 8;
    localparam int WAVE_LENGTH = 2646;
    localparam int NUM_WAVES   = 8;
    localparam int CLK_W       = 40;

    localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int POS_W      = (WAVE_LENGTH > 1) ? $clog2(WAVE_LENGTH) : 1;
    localparam int BANK_DEPTH = NUM_WAVES * WAVE_LENGTH;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int ADDR_X_W   = BANK_AW + 3;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam int QDEPTH = 2;

    localparam logic [15:0] WINDOW_RESET = 16'd8820;
    localparam logic signed [17:0] SAMPLE_MIN = -18'sd32768;
    localparam logic signed [17:0] SAMPLE_MAX = 18'sd32767;

    typedef enum logic [1:0] {
        OP_TRIGGER = 2'd0,
        OP_TICK    = 2'd1,
        OP_RESET   = 2'd2,
        OP_BANK    = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED = 1'b0,
        CFG_WINDOW  = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRG_ANCHOR,
        ST_TRG_OFF,
        ST_TRG_START,
        ST_TRG_DIFF,
        ST_TRG_PLACE,
        ST_TICK_ISSUE,
        ST_TICK_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t         op;
        logic [39:0] event_time;
        logic [15:0] event_gain;
        logic [2:0]  variant;
        logic [15:0] sample_in;
        logic        end_of_buffer;
        logic [11:0] bank_index;
        logic [15:0] bank_value;
    } cmd_t;

    function automatic logic [BANK_AW-1:0] bank_addr(input logic [2:0] wave,
                                                     input logic [POS_W-1:0] pos);
        logic [ADDR_X_W-1:0] a;
        a = ADDR_X_W'(wave) * ADDR_X_W'(WAVE_LENGTH) + ADDR_X_W'(pos);
        return a[BANK_AW-1:0];
    endfunction

    function automatic logic [3:0] count_sat(input logic [NUM_VOICES-1:0] bits);
        logic [VIDX_W+1:0] n;
        n = '0;
        for (int i = 0; i < NUM_VOICES; i++)
        begin
            n = n + (VIDX_W+2)'(bits[i]);
        end
        if (n > (VIDX_W+2)'(15))
        begin
            return 4'd15;
        end
        return n[3:0];
    endfunction

endpackage

>>> hw/rtl/oneshot_sample_voice_mixer.sv
// One-shot sample voice mixer with eight voices.
// Input stream (s_*): one item per command. s_tuser carries the opcode
// (trigger, sample tick, reset voices, bank write), s_tlast marks the last
// tick of an audio buffer, s_tdata carries the remaining fields.
// Output stream (m_*): exactly one item per input item, in order, with the
// mixed sample on a tick, the voice-taken flag and the active voice count.
// Configuration: cfg_we with cfg_index 0 (enable) or 1 (re-anchor window);
// write only while the block is idle.
// Items pass through a two-entry command queue into a sequencer that works
// on one item at a time. An enabled trigger steps through queue pop, anchor,
// three 40-bit add steps, placement and result; an enabled tick through pop,
// one voice per cycle through the bank read, multiply and clamp pipeline,
// drain and result; reset, bank write and disabled items through pop and
// result. With the output free the sequencer returns to idle and takes the
// next queued item.
// Reset clears voices, anchor and sample clock; enable returns to 1 and the
// window to 8820. The waveform bank is not cleared and must be written
// before it is played. When m_tready is low the result is held in the
// output register; the queue keeps taking items until it is full.
module oneshot_sample_voice_mixer (
    input  logic                               clk,
    input  logic                               rst_n,
    // tdata: event_time[39:0], event_gain[55:40], variant[58:56],
    //        sample_in[74:59], bank_index[86:75], bank_value[102:87], zero[103]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [osvm_pkg::IN_TDATA_W-1:0]    s_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]                         s_tuser,
    input  logic                               s_tlast,
    // tdata: sample_out[15:0], voice_taken[16], active_voices[20:17], zero[23:21]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [osvm_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                               cfg_we,
    input  logic [osvm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [osvm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import osvm_pkg::*;

    logic        enabled_reg;
    logic [15:0] window_reg;
    logic        cmd_valid;
    cmd_t        cmd;
    logic        cmd_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b1;
            window_reg  <= WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ENABLED: enabled_reg <= cfg_data[0];
                CFG_WINDOW:  window_reg  <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    osvm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    osvm_engine u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .enabled         (enabled_reg),
        .reanchor_window (window_reg),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

endmodule

>>> hw/rtl/osvm_front.sv
module osvm_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [osvm_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic [1:0]                         s_tuser,
    input  logic                               s_tlast,
    output logic                               cmd_valid,
    output osvm_pkg::cmd_t                     cmd,
    input  logic                               cmd_pop
);
    import osvm_pkg::*;

    cmd_t        q_reg [QDEPTH];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    cmd_t        decoded;
    logic        push;

    always_comb
    begin
        decoded.op            = op_t'(s_tuser);
        decoded.event_time    = s_tdata[39:0];
        decoded.event_gain    = s_tdata[55:40];
        decoded.variant       = s_tdata[58:56];
        decoded.sample_in     = s_tdata[74:59];
        decoded.end_of_buffer = s_tlast;
        decoded.bank_index    = s_tdata[86:75];
        decoded.bank_value    = s_tdata[102:87];
    end

    assign s_tready  = (count_reg != 2'(QDEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, cmd_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> hw/rtl/osvm_engine.sv
module osvm_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               enabled,
    input  logic [15:0]                        reanchor_window,
    input  logic                               cmd_valid,
    input  osvm_pkg::cmd_t                     cmd,
    output logic                               cmd_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [osvm_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import osvm_pkg::*;

    state_t state_reg;
    state_t state_next;

    cmd_t                    cmd_reg;
    logic [VIDX_W-1:0]       vi_reg;
    logic [POS_W-1:0]        pos_reg   [NUM_VOICES];
    logic [CLK_W-1:0]        start_reg [NUM_VOICES];
    logic [15:0]             gain_reg  [NUM_VOICES];
    logic [2:0]              wave_reg  [NUM_VOICES];
    logic                    anchored_reg;
    logic [CLK_W-1:0]        anchor_time_reg;
    logic [CLK_W-1:0]        anchor_clock_reg;
    logic [CLK_W-1:0]        clock_reg;
    logic [CLK_W-1:0]        work_reg;
    logic [CLK_W-1:0]        diff_reg;
    logic signed [15:0]      acc_reg;
    logic                    p1_valid_reg;
    logic                    p1_play_reg;
    logic [15:0]             p1_gain_reg;
    logic                    p1_wok_reg;
    logic                    p2_valid_reg;
    logic signed [32:0]      p2_prod_reg;
    logic [15:0]             res_sample_reg;
    logic                    res_taken_reg;
    logic                    out_valid_reg;
    logic [OUT_TDATA_W-1:0]  out_data_reg;

    logic [15:0]             bank_mem [BANK_DEPTH];
    logic signed [15:0]      rd_data;

    logic [NUM_VOICES-1:0]   busy;
    logic                    free_found;
    logic [VIDX_W-1:0]       free_idx;
    logic                    out_free;
    logic [CLK_W-1:0]        etime;
    logic                    late;
    logic [CLK_W-1:0]        mag;
    logic                    far;
    logic [CLK_W-1:0]        start_eff;
    logic [CLK_W-1:0]        since_start;
    logic                    play0;
    logic                    wave_ok;
    logic                    pos_last;
    logic [BANK_AW-1:0]      rd_addr;
    logic                    bank_we;
    logic [BANK_AW-1:0]      wr_addr;
    logic signed [15:0]      rd_word;
    logic signed [32:0]      prod;
    logic signed [16:0]      contrib;
    logic signed [17:0]      mix;
    logic signed [15:0]      mix_clamped;
    logic [CLK_W-1:0]        clock_inc;

    always_comb
    begin
        for (int v = 0; v < NUM_VOICES; v++)
        begin
            busy[v] = (gain_reg[v] != 16'd0);
        end
        free_found = 1'b0;
        free_idx   = '0;
        for (int v = NUM_VOICES - 1; v >= 0; v--)
        begin
            if (!busy[v])
            begin
                free_found = 1'b1;
                free_idx   = VIDX_W'(v);
            end
        end
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign etime     = cmd_reg.event_time[CLK_W-1:0];
    assign clock_inc = clock_reg + CLK_W'(1);

    // Distance from clock to start, taken as a signed value.
    assign late      = diff_reg[CLK_W-1];
    assign mag       = late ? (~diff_reg + CLK_W'(1)) : diff_reg;
    assign far       = (mag > CLK_W'(reanchor_window));
    assign start_eff = (far || late) ? clock_reg : work_reg;

    assign since_start = clock_reg - start_reg[vi_reg];
    assign play0       = busy[vi_reg] && !since_start[CLK_W-1];
    assign wave_ok     = ({1'b0, wave_reg[vi_reg]} < 4'(NUM_WAVES));
    assign pos_last    = ((POS_W+1)'(pos_reg[vi_reg]) + (POS_W+1)'(1))
                         >= (POS_W+1)'(WAVE_LENGTH);
    assign rd_addr     = wave_ok ? bank_addr(wave_reg[vi_reg], pos_reg[vi_reg]) : '0;

    assign bank_we = (state_reg == ST_IDLE) && cmd_valid && (cmd.op == OP_BANK)
                     && ({1'b0, cmd.variant} < 4'(NUM_WAVES))
                     && ({1'b0, cmd.bank_index} < 13'(WAVE_LENGTH));
    assign wr_addr = bank_addr(cmd.variant, cmd.bank_index[POS_W-1:0]);

    // Bank word times Q0.16 gain, then truncate toward zero.
    assign rd_word = p1_wok_reg ? rd_data : 16'sd0;
    assign prod    = rd_word * $signed({1'b0, p1_gain_reg});
    assign contrib = p2_prod_reg[32:16]
                     + 17'(p2_prod_reg[32] && (p2_prod_reg[15:0] != 16'd0));
    assign mix     = 18'(acc_reg) + 18'(contrib);
    always_comb
    begin
        if (mix < SAMPLE_MIN)
        begin
            mix_clamped = SAMPLE_MIN[15:0];
        end
        else if (mix > SAMPLE_MAX)
        begin
            mix_clamped = SAMPLE_MAX[15:0];
        end
        else
        begin
            mix_clamped = mix[15:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_TRIGGER: state_next = enabled ? ST_TRG_ANCHOR : ST_DONE;
                        OP_TICK:    state_next = enabled ? ST_TICK_ISSUE : ST_DONE;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_TRG_ANCHOR: state_next = ST_TRG_OFF;
            ST_TRG_OFF:    state_next = ST_TRG_START;
            ST_TRG_START:  state_next = ST_TRG_DIFF;
            ST_TRG_DIFF:   state_next = ST_TRG_PLACE;
            ST_TRG_PLACE:  state_next = ST_DONE;
            ST_TICK_ISSUE:
            begin
                if (vi_reg == VIDX_W'(NUM_VOICES - 1))
                begin
                    state_next = ST_TICK_DRAIN;
                end
            end
            ST_TICK_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bank_we)
        begin
            bank_mem[wr_addr] <= cmd.bank_value;
        end
        rd_data <= $signed(bank_mem[rd_addr]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg          <= '0;
            vi_reg           <= '0;
            for (int v = 0; v < NUM_VOICES; v++)
            begin
                pos_reg[v]   <= '0;
                start_reg[v] <= '0;
                gain_reg[v]  <= '0;
                wave_reg[v]  <= '0;
            end
            anchored_reg     <= 1'b0;
            anchor_time_reg  <= '0;
            anchor_clock_reg <= '0;
            clock_reg        <= '0;
            work_reg         <= '0;
            diff_reg         <= '0;
            acc_reg          <= '0;
            p1_valid_reg     <= 1'b0;
            p1_play_reg      <= 1'b0;
            p1_gain_reg      <= '0;
            p1_wok_reg       <= 1'b0;
            p2_valid_reg     <= 1'b0;
            p2_prod_reg      <= '0;
            res_sample_reg   <= '0;
            res_taken_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
        end
        else
        begin
            // Mixing pipeline: bank read, multiply, accumulate.
            p1_valid_reg <= (state_reg == ST_TICK_ISSUE);
            p1_play_reg  <= play0;
            p1_gain_reg  <= gain_reg[vi_reg];
            p1_wok_reg   <= wave_ok;
            p2_valid_reg <= p1_valid_reg;
            p2_prod_reg  <= p1_play_reg ? prod : 33'sd0;
            if (p2_valid_reg)
            begin
                acc_reg <= mix_clamped;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg        <= cmd;
                        res_sample_reg <= ((cmd.op == OP_TICK) && !enabled) ? cmd.sample_in
                                                                             : '0;
                        res_taken_reg  <= 1'b0;
                        vi_reg         <= '0;
                        acc_reg        <= $signed(cmd.sample_in);
                        if (!enabled || (cmd.op == OP_RESET))
                        begin
                            for (int v = 0; v < NUM_VOICES; v++)
                            begin
                                gain_reg[v] <= '0;
                            end
                            anchored_reg <= 1'b0;
                        end
                        if ((cmd.op == OP_TICK) && !enabled)
                        begin
                            clock_reg <= clock_inc;
                        end
                    end
                end
                ST_TRG_ANCHOR:
                begin
                    if (!anchored_reg)
                    begin
                        anchor_time_reg  <= etime;
                        anchor_clock_reg <= clock_reg;
                        anchored_reg     <= 1'b1;
                    end
                end
                ST_TRG_OFF:
                begin
                    work_reg <= etime - anchor_time_reg;
                end
                ST_TRG_START:
                begin
                    work_reg <= anchor_clock_reg + work_reg;
                end
                ST_TRG_DIFF:
                begin
                    diff_reg <= work_reg - clock_reg;
                end
                ST_TRG_PLACE:
                begin
                    if (far)
                    begin
                        anchor_time_reg  <= etime;
                        anchor_clock_reg <= clock_reg;
                    end
                    if ((cmd_reg.event_gain != 16'd0) && free_found)
                    begin
                        pos_reg[free_idx]   <= '0;
                        start_reg[free_idx] <= start_eff;
                        gain_reg[free_idx]  <= cmd_reg.event_gain;
                        wave_reg[free_idx]  <= cmd_reg.variant;
                        res_taken_reg       <= 1'b1;
                    end
                end
                ST_TICK_ISSUE:
                begin
                    vi_reg <= vi_reg + VIDX_W'(1);
                    if (play0)
                    begin
                        // Advance the voice; free it after its last word.
                        if (pos_last)
                        begin
                            gain_reg[vi_reg] <= '0;
                            pos_reg[vi_reg]  <= '0;
                        end
                        else
                        begin
                            pos_reg[vi_reg] <= pos_reg[vi_reg] + POS_W'(1);
                        end
                    end
                end
                ST_TICK_DRAIN:
                begin
                    if (!p1_valid_reg && !p2_valid_reg)
                    begin
                        res_sample_reg <= acc_reg;
                        clock_reg      <= clock_inc;
                        if (cmd_reg.end_of_buffer && (busy == '0))
                        begin
                            anchored_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {3'b000, count_sat(busy), res_taken_reg, res_sample_reg};
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
